### rtl/core/rrlh_pkg.sv
// Shared types and constants for the round-robin lock hand-off arbiter.
// No dependencies; imported by every module of the arbiter.
`default_nettype none

package rrlh_pkg;

    // Fixed field widths of the item and result ports
    localparam int OP_W       = 2;
    localparam int SLOT_W     = 6;
    localparam int STATUS_W   = 3;
    localparam int SLOT_RANGE = 1 << SLOT_W;

    // Hand-off search works on groups of this many slots per first stage
    localparam int GROUP_W     = 8;
    localparam int GROUP_POS_W = 3;

    // Operation codes as they arrive on the input
    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_TRY     = 2'd1,
        OP_RELEASE = 2'd2,
        OP_UNKNOWN = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 3'd0,
        ST_WAIT     = 3'd1,
        ST_BUSY     = 3'd2,
        ST_FREED    = 3'd3,
        ST_HANDED   = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    // Back-end sequencer states
    typedef enum logic {
        BK_FETCH = 1'b0,
        BK_EXEC  = 1'b1
    } back_state_t;

endpackage

`default_nettype wire

### rtl/core/rrlh_front.sv
// Front end: accepts items, folds the slot into the ring, decodes the operation
// and holds them in a two-entry command queue. Depends on rrlh_pkg.
`default_nettype none

module rrlh_front #(
    parameter int NUM_SLOTS = 64,
    localparam int IDX_W = $clog2(NUM_SLOTS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [rrlh_pkg::OP_W-1:0]   operation,
    input  wire logic [rrlh_pkg::SLOT_W-1:0] slot,
    output logic                             cmd_valid,
    input  wire logic                        cmd_pop,
    output rrlh_pkg::op_t                    cmd_op,
    output logic [IDX_W-1:0]                 cmd_slot
);
    import rrlh_pkg::*;

    logic [IDX_W-1:0] slot_mod [SLOT_RANGE];
    op_t              op_q     [2];
    logic [IDX_W-1:0] slot_q   [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push;
    op_t              op_dec;

    // Slot modulo ring size, resolved at elaboration
    for (genvar g = 0; g < SLOT_RANGE; g++) begin : g_mod
        assign slot_mod[g] = IDX_W'(g % NUM_SLOTS);
    end

    assign op_dec    = op_t'(operation);
    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign cmd_op    = op_q[rd_ptr_reg];
    assign cmd_slot  = slot_q[rd_ptr_reg];

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ cmd_pop;
        count_next  = count_reg;
        if (do_push && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            op_q[wr_ptr_reg]   <= op_dec;
            slot_q[wr_ptr_reg] <= slot_mod[slot];
        end
    end

endmodule

`default_nettype wire

### rtl/core/rrlh_search.sv
// Two-stage rotated priority search for the next slot with waiters.
// Stage one scans groups of slots, stage two picks the group. Depends on rrlh_pkg.
`default_nettype none

module rrlh_search #(
    parameter int NUM_SLOTS = 64,
    localparam int IDX_W = $clog2(NUM_SLOTS)
) (
    input  wire logic                 clk,
    input  wire logic                 load,
    input  wire logic [NUM_SLOTS-1:0] flags,
    input  wire logic [IDX_W-1:0]     start,
    output logic                      found,
    output logic [IDX_W-1:0]          found_idx
);
    import rrlh_pkg::*;

    localparam int NG    = (NUM_SLOTS + GROUP_W - 1) / GROUP_W;
    localparam int PAD_W = NG * GROUP_W;
    localparam logic [PAD_W-1:0] ONES = '1;

    logic [PAD_W-1:0]       flags_pad;
    logic [PAD_W-1:0]       ge_mask;
    logic [PAD_W-1:0]       hi_vec;
    logic [PAD_W-1:0]       lo_vec;
    logic [NG-1:0]          hi_any_next, lo_any_next;
    logic [GROUP_POS_W-1:0] hi_pos_next [NG];
    logic [GROUP_POS_W-1:0] lo_pos_next [NG];
    logic [NG-1:0]          hi_any_reg, lo_any_reg;
    logic [GROUP_POS_W-1:0] hi_pos_reg  [NG];
    logic [GROUP_POS_W-1:0] lo_pos_reg  [NG];

    // Slots after the start point, and slots before it (the wrap)
    assign flags_pad = PAD_W'(flags);
    assign ge_mask   = ONES << start;
    assign hi_vec    = flags_pad & (ge_mask << 1);
    assign lo_vec    = flags_pad & ~ge_mask;

    // Stage one: lowest set bit inside each group
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            hi_any_next[g] = 1'b0;
            lo_any_next[g] = 1'b0;
            hi_pos_next[g] = '0;
            lo_pos_next[g] = '0;
            for (int b = GROUP_W - 1; b >= 0; b--)
            begin
                if (hi_vec[g * GROUP_W + b])
                begin
                    hi_any_next[g] = 1'b1;
                    hi_pos_next[g] = GROUP_POS_W'(b);
                end
                if (lo_vec[g * GROUP_W + b])
                begin
                    lo_any_next[g] = 1'b1;
                    lo_pos_next[g] = GROUP_POS_W'(b);
                end
            end
        end
    end

    // Captured with the command, held while the back end waits to commit
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hi_any_reg <= hi_any_next;
            lo_any_reg <= lo_any_next;
            for (int g = 0; g < NG; g++)
            begin
                hi_pos_reg[g] <= hi_pos_next[g];
                lo_pos_reg[g] <= lo_pos_next[g];
            end
        end
    end

    // Stage two: lowest group with a hit, after-start side first
    always_comb
    begin
        int hi_g;
        int lo_g;
        hi_g = 0;
        lo_g = 0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (hi_any_reg[g])
            begin
                hi_g = g;
            end
            if (lo_any_reg[g])
            begin
                lo_g = g;
            end
        end
        found = (|hi_any_reg) || (|lo_any_reg);
        if (|hi_any_reg)
        begin
            found_idx = IDX_W'(hi_g * GROUP_W + int'(hi_pos_reg[hi_g]));
        end
        else
        begin
            found_idx = IDX_W'(lo_g * GROUP_W + int'(lo_pos_reg[lo_g]));
        end
    end

endmodule

`default_nettype wire

### rtl/core/rrlh_back.sv
// Back end: waiter count memory, nonzero flags, lock bit and the result register.
// Runs one command per fetch/execute pair. Depends on rrlh_pkg and rrlh_search.
`default_nettype none

module rrlh_back #(
    parameter int NUM_SLOTS  = 64,
    parameter int COUNT_BITS = 8,
    localparam int IDX_W = $clog2(NUM_SLOTS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_pop,
    input  wire rrlh_pkg::op_t               cmd_op,
    input  wire logic [IDX_W-1:0]            cmd_slot,
    output logic                             empty,
    input  wire logic                        pop,
    output rrlh_pkg::status_t                status,
    output logic [rrlh_pkg::SLOT_W-1:0]      granted_slot
);
    import rrlh_pkg::*;

    back_state_t            state_reg, state_next;
    op_t                    op_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic [COUNT_BITS-1:0]  count_mem [NUM_SLOTS];
    logic [COUNT_BITS-1:0]  rd_data_reg;
    logic [NUM_SLOTS-1:0]   flags_reg, flags_next;
    logic                   held_reg, held_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic                   out_room;
    logic                   commit;
    logic                   found;
    logic [IDX_W-1:0]       found_idx;
    logic [COUNT_BITS-1:0]  cnt;
    logic                   cnt_max;
    logic                   wr_en;
    logic [COUNT_BITS-1:0]  wr_data;
    logic                   exec_held;
    status_t                res_status;
    logic [IDX_W-1:0]       res_idx;
    logic [15:0]            res_idx_wide;

    rrlh_search #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_search (
        .clk      (clk),
        .load     (cmd_pop),
        .flags    (flags_reg),
        .start    (cmd_slot),
        .found    (found),
        .found_idx(found_idx)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_FETCH:
            begin
                if (cmd_valid)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (out_room)
                begin
                    state_next = BK_FETCH;
                end
            end
            default: state_next = BK_FETCH;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        cmd_pop = 1'b0;
        commit  = 1'b0;
        unique case (state_reg)
            BK_FETCH: cmd_pop = cmd_valid;
            BK_EXEC:  commit  = out_room;
            default:
            begin
                cmd_pop = 1'b0;
                commit  = 1'b0;
            end
        endcase
    end

    assign out_room = !out_valid_reg || pop;

    // A slot with a clear flag holds zero, whatever the memory says
    assign cnt     = flags_reg[slot_reg] ? rd_data_reg : '0;
    assign cnt_max = (cnt == {COUNT_BITS{1'b1}});

    // Execute one command
    always_comb
    begin
        wr_en      = 1'b0;
        wr_data    = cnt;
        exec_held  = held_reg;
        res_status = ST_BUSY;
        res_idx    = '0;
        unique case (op_reg)
            OP_ACQUIRE:
            begin
                if (cnt_max)
                begin
                    res_status = ST_OVERFLOW;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_data = cnt + COUNT_BITS'(1);
                    if (!held_reg)
                    begin
                        exec_held  = 1'b1;
                        res_status = ST_GRANTED;
                        res_idx    = slot_reg;
                    end
                    else
                    begin
                        res_status = ST_WAIT;
                    end
                end
            end
            OP_TRY:
            begin
                if (held_reg)
                begin
                    res_status = ST_BUSY;
                end
                else if (cnt_max)
                begin
                    res_status = ST_OVERFLOW;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = cnt + COUNT_BITS'(1);
                    exec_held  = 1'b1;
                    res_status = ST_GRANTED;
                    res_idx    = slot_reg;
                end
            end
            OP_RELEASE:
            begin
                if (!held_reg)
                begin
                    res_status = ST_FREED;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_data = (cnt == '0) ? '0 : cnt - COUNT_BITS'(1);
                    if (found)
                    begin
                        res_status = ST_HANDED;
                        res_idx    = found_idx;
                    end
                    else if (wr_data != '0)
                    begin
                        res_status = ST_HANDED;
                        res_idx    = slot_reg;
                    end
                    else
                    begin
                        exec_held  = 1'b0;
                        res_status = ST_FREED;
                    end
                end
            end
            OP_UNKNOWN: res_status = ST_BUSY;
            default:    res_status = ST_BUSY;
        endcase
    end

    assign res_idx_wide = 16'(res_idx);

    // Control state updates
    always_comb
    begin
        flags_next     = flags_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (commit)
        begin
            out_valid_next = 1'b1;
            held_next      = exec_held;
            if (wr_en)
            begin
                flags_next[slot_reg] = (wr_data != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_FETCH;
            flags_reg     <= '0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flags_reg     <= flags_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            op_reg   <= cmd_op;
            slot_reg <= cmd_slot;
        end
        if (commit)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_idx_wide[SLOT_W-1:0];
        end
    end

    // Waiter count memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (commit && wr_en)
        begin
            count_mem[slot_reg] <= wr_data;
        end
        if (cmd_pop)
        begin
            rd_data_reg <= count_mem[cmd_slot];
        end
    end

    assign empty        = !out_valid_reg;
    assign status       = out_status_reg;
    assign granted_slot = out_slot_reg;

endmodule

`default_nettype wire

### rtl/core/round_robin_lock_handoff_arbiter_core.sv
// Round-robin lock hand-off arbiter, top level: front queue plus back-end executor.
// An accepted item is queued, then fetched by the back end (count memory read and
// stage one of the hand-off search registered), then executed into the result register;
// the next fetch waits for that commit, which waits for room in the result register.
// Reset: asynchronous, clears lock bit, nonzero flags and queues; counts read as zero
// through the flags at once, so no clearing pass is needed. Depends on rrlh_pkg.
`default_nettype none

module round_robin_lock_handoff_arbiter_core #(
    parameter int NUM_SLOTS  = 64,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [rrlh_pkg::OP_W-1:0]     operation,
    input  wire logic [rrlh_pkg::SLOT_W-1:0]   slot,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [rrlh_pkg::STATUS_W-1:0]      status,
    output logic [rrlh_pkg::SLOT_W-1:0]        granted_slot
);
    import rrlh_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);

    logic             cmd_valid;
    logic             cmd_pop;
    op_t              cmd_op;
    logic [IDX_W-1:0] cmd_slot;
    status_t          status_int;

    rrlh_front #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .operation(operation),
        .slot     (slot),
        .cmd_valid(cmd_valid),
        .cmd_pop  (cmd_pop),
        .cmd_op   (cmd_op),
        .cmd_slot (cmd_slot)
    );

    rrlh_back #(
        .NUM_SLOTS (NUM_SLOTS),
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd_op      (cmd_op),
        .cmd_slot    (cmd_slot),
        .empty       (empty),
        .pop         (pop),
        .status      (status_int),
        .granted_slot(granted_slot)
    );

    assign status = status_int;

endmodule

`default_nettype wire
